>>> src/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FTPP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ftpp_pkg.sv
`timescale 1ns / 1ps
package ftpp_pkg;

    localparam int unsigned SizeFieldBytes = 4;

    typedef enum logic [2:0] {
        REG_DATA_CODE  = 3'd0,
        REG_START_CODE = 3'd1,
        REG_END_CODE   = 3'd2,
        REG_SIZE_TYPE  = 3'd3,
        REG_NAME_TYPE  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        OK_NONE    = 2'd0,
        OK_PAYLOAD = 2'd1,
        OK_NAME    = 2'd2,
        OK_STATUS  = 2'd3
    } t_out_kind;

    typedef enum logic [1:0] {
        PK_DATA    = 2'd0,
        PK_START   = 2'd1,
        PK_END     = 2'd2,
        PK_UNKNOWN = 2'd3
    } t_pkt_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_CTRL  = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_LEN_ERR   = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_SIZE_DIFF = 3'd5
    } t_status;

    typedef enum logic [12:0] {
        PH_IDLE = 13'b0000000000001,
        PH_DSEQ = 13'b0000000000010,
        PH_DLHI = 13'b0000000000100,
        PH_DLLO = 13'b0000000001000,
        PH_DPAY = 13'b0000000010000,
        PH_CT1  = 13'b0000000100000,
        PH_CL1  = 13'b0000001000000,
        PH_CV1  = 13'b0000010000000,
        PH_CT2  = 13'b0000100000000,
        PH_CL2  = 13'b0001000000000,
        PH_CV2  = 13'b0010000000000,
        PH_DONE = 13'b0100000000000,
        PH_SKIP = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        t_out_kind out_kind;
        logic [7:0]  out_byte;
        logic [7:0]  seq_num;
        logic [31:0] file_size;
        t_pkt_kind   packet_kind;
        t_status     status;
        logic        last_result;
    } t_result;

endpackage

>>> src/ftpp_ifs.sv
`timescale 1ns / 1ps
interface ftpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, byte_in, first_byte, last_byte, input ready);
    modport sink (input valid, byte_in, first_byte, last_byte, output ready);
endinterface

interface ftpp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [7:0]  seq_num;
    logic [31:0] file_size;
    logic [1:0]  packet_kind;
    logic [2:0]  status;
    logic        last_result;

    modport source (output valid, out_kind, out_byte, seq_num, file_size, packet_kind,
                    status, last_result, input ready);
    modport sink (input valid, out_kind, out_byte, seq_num, file_size, packet_kind,
                  status, last_result, output ready);
endinterface

>>> src/file_transfer_packet_parser.sv
`timescale 1ns / 1ps
// Parser for received file-transfer packets, fed one byte per request with first and
// last flags from the link layer. Every byte is parsed in the cycle it is accepted and
// gives one result (a payload byte, a name byte or an empty result); the byte that ends
// a packet gives a second result carrying the packet status. Results are written into a
// four-entry output queue as the byte is taken and leave it one per cycle while the
// output is ready. The block takes one byte per cycle as long as two queue entries are
// free, so the rate at which the queue drains sets the rate of input bytes, and each
// packet end adds one more result to drain. Control codes and TLV types are set through
// the APB registers at byte addresses 0 (data code), 4 (start code), 8 (end code),
// 12 (size type) and 16 (name type).
`include "assert_macros.svh"

module file_transfer_packet_parser
    import ftpp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    ftpp_in_if.sink      i_in_ch,
    ftpp_out_if.source   o_out_ch
);

    localparam int unsigned Depth = 4;

    // Configuration registers.
    logic [7:0] r_data_code, r_start_code, r_end_code, r_size_type, r_name_type;
    t_reg_idx   w_reg_idx;
    logic       w_cfg_write;

    // Parse state.
    t_phase      r_phase, n_phase;
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_data_length, n_data_length;
    logic [7:0]  r_tlv_length, n_tlv_length;
    logic [31:0] r_size_acc, n_size_acc;
    logic [31:0] r_start_size, n_start_size;
    logic [7:0]  r_seq, n_seq;
    t_pkt_kind   r_kind, n_kind;
    t_status     r_err, n_err;
    logic        r_have_start, n_have_start;

    // Output queue.
    t_result     r_queue [Depth];
    logic [1:0]  r_wr_ptr, r_rd_ptr;
    logic [2:0]  r_count, n_count;
    t_result     w_res0, w_res1;
    t_out_kind   w_byte_kind;
    logic        w_accept, w_pop;

    assign w_reg_idx   = t_reg_idx'(paddr[4:2]);
    assign w_cfg_write = psel && penable && pwrite;
    assign pready      = 1'b1;

    always_comb begin
        unique case (w_reg_idx)
            REG_DATA_CODE:  prdata = {24'd0, r_data_code};
            REG_START_CODE: prdata = {24'd0, r_start_code};
            REG_END_CODE:   prdata = {24'd0, r_end_code};
            REG_SIZE_TYPE:  prdata = {24'd0, r_size_type};
            REG_NAME_TYPE:  prdata = {24'd0, r_name_type};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_code  <= 8'd1;
            r_start_code <= 8'd2;
            r_end_code   <= 8'd3;
            r_size_type  <= 8'd0;
            r_name_type  <= 8'd1;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                REG_DATA_CODE:  r_data_code  <= pwdata[7:0];
                REG_START_CODE: r_start_code <= pwdata[7:0];
                REG_END_CODE:   r_end_code   <= pwdata[7:0];
                REG_SIZE_TYPE:  r_size_type  <= pwdata[7:0];
                REG_NAME_TYPE:  r_name_type  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign i_in_ch.ready = (r_count <= 3'(Depth - 2));
    assign w_accept      = i_in_ch.valid && i_in_ch.ready;
    assign w_pop         = o_out_ch.valid && o_out_ch.ready;

    // Parse one byte; the status checks at a packet end see the updated state.
    always_comb begin
        logic [7:0]  b;
        logic [15:0] cnt_inc;
        b             = i_in_ch.byte_in;
        cnt_inc       = r_byte_count + 16'd1;
        n_phase       = r_phase;
        n_byte_count  = r_byte_count;
        n_data_length = r_data_length;
        n_tlv_length  = r_tlv_length;
        n_size_acc    = r_size_acc;
        n_start_size  = r_start_size;
        n_seq         = r_seq;
        n_kind        = r_kind;
        n_err         = r_err;
        n_have_start  = r_have_start;
        w_byte_kind   = OK_NONE;

        if (i_in_ch.first_byte || r_phase == PH_IDLE) begin
            n_err         = ST_OK;
            n_byte_count  = 16'd0;
            n_data_length = 16'd0;
            n_tlv_length  = 8'd0;
            if (b == r_data_code) begin
                n_kind  = PK_DATA;
                n_phase = PH_DSEQ;
            end else if (b == r_start_code || b == r_end_code) begin
                n_kind     = (b == r_start_code) ? PK_START : PK_END;
                n_size_acc = 32'd0;
                n_phase    = PH_CT1;
            end else begin
                n_kind  = PK_UNKNOWN;
                n_err   = ST_BAD_CTRL;
                n_phase = PH_SKIP;
            end
        end else begin
            unique case (r_phase)
                PH_DSEQ: begin
                    n_seq   = b;
                    n_phase = PH_DLHI;
                end
                PH_DLHI: begin
                    n_data_length = {b, 8'd0};
                    n_phase       = PH_DLLO;
                end
                PH_DLLO: begin
                    n_data_length = {r_data_length[15:8], b};
                    n_byte_count  = 16'd0;
                    n_phase       = ({r_data_length[15:8], b} == 16'd0) ? PH_DONE : PH_DPAY;
                end
                PH_DPAY: begin
                    w_byte_kind  = OK_PAYLOAD;
                    n_byte_count = cnt_inc;
                    if (cnt_inc == r_data_length) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_CT1: begin
                    if (b == r_size_type) begin
                        n_phase = PH_CL1;
                    end else begin
                        if (n_err == ST_OK) n_err = ST_BAD_TYPE;
                        n_phase = PH_SKIP;
                    end
                end
                PH_CL1: begin
                    n_tlv_length = b;
                    n_size_acc   = 32'd0;
                    if (b > 8'(SizeFieldBytes) && n_err == ST_OK) n_err = ST_OVERFLOW;
                    n_phase = (b == 8'd0) ? PH_CT2 : PH_CV1;
                end
                PH_CV1: begin
                    if (r_size_acc[31:24] != 8'd0 && n_err == ST_OK) n_err = ST_OVERFLOW;
                    n_size_acc   = {r_size_acc[23:0], b};
                    n_tlv_length = r_tlv_length - 8'd1;
                    if (r_tlv_length == 8'd1) begin
                        n_phase = PH_CT2;
                    end
                end
                PH_CT2: begin
                    if (b == r_name_type) begin
                        n_phase = PH_CL2;
                    end else begin
                        if (n_err == ST_OK) n_err = ST_BAD_TYPE;
                        n_phase = PH_SKIP;
                    end
                end
                PH_CL2: begin
                    n_tlv_length = b;
                    n_phase      = (b == 8'd0) ? PH_DONE : PH_CV2;
                end
                PH_CV2: begin
                    w_byte_kind  = OK_NAME;
                    n_tlv_length = r_tlv_length - 8'd1;
                    if (r_tlv_length == 8'd1) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    if (n_err == ST_OK) n_err = ST_LEN_ERR;
                    n_phase = PH_SKIP;
                end
                default: ;
            endcase
        end

        w_res0.out_kind    = w_byte_kind;
        w_res0.out_byte    = (w_byte_kind != OK_NONE) ? b : 8'd0;
        w_res0.seq_num     = n_seq;
        w_res0.file_size   = n_size_acc;
        w_res0.packet_kind = n_kind;
        w_res0.status      = ST_OK;
        w_res0.last_result = !i_in_ch.last_byte;

        if (i_in_ch.last_byte) begin
            // A packet that stops before its last field is a length error.
            if (n_phase != PH_DONE && n_phase != PH_SKIP && n_err == ST_OK) begin
                n_err = ST_LEN_ERR;
            end
            if (n_kind == PK_START) begin
                if (n_err == ST_OK) begin
                    n_start_size = n_size_acc;
                    n_have_start = 1'b1;
                end
            end else if (n_kind == PK_END) begin
                if (n_err == ST_OK && (!r_have_start || n_size_acc != r_start_size)) begin
                    n_err = ST_SIZE_DIFF;
                end
                n_have_start = 1'b0;
            end
            n_phase = PH_IDLE;
        end

        w_res1.out_kind    = OK_STATUS;
        w_res1.out_byte    = 8'd0;
        w_res1.seq_num     = n_seq;
        w_res1.file_size   = n_size_acc;
        w_res1.packet_kind = n_kind;
        w_res1.status      = n_err;
        w_res1.last_result = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_byte_count  <= 16'd0;
            r_data_length <= 16'd0;
            r_tlv_length  <= 8'd0;
            r_size_acc    <= 32'd0;
            r_start_size  <= 32'd0;
            r_seq         <= 8'd0;
            r_kind        <= PK_UNKNOWN;
            r_err         <= ST_OK;
            r_have_start  <= 1'b0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_byte_count  <= n_byte_count;
            r_data_length <= n_data_length;
            r_tlv_length  <= n_tlv_length;
            r_size_acc    <= n_size_acc;
            r_start_size  <= n_start_size;
            r_seq         <= n_seq;
            r_kind        <= n_kind;
            r_err         <= n_err;
            r_have_start  <= n_have_start;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            n_count = n_count + (i_in_ch.last_byte ? 3'd2 : 3'd1);
        end
        if (w_pop) begin
            n_count = n_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_wr_ptr <= r_wr_ptr + (i_in_ch.last_byte ? 2'd2 : 2'd1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_queue[r_wr_ptr] <= w_res0;
            if (i_in_ch.last_byte) begin
                r_queue[r_wr_ptr + 2'd1] <= w_res1;
            end
        end
    end

    assign o_out_ch.valid       = (r_count != 3'd0);
    assign o_out_ch.out_kind    = r_queue[r_rd_ptr].out_kind;
    assign o_out_ch.out_byte    = r_queue[r_rd_ptr].out_byte;
    assign o_out_ch.seq_num     = r_queue[r_rd_ptr].seq_num;
    assign o_out_ch.file_size   = r_queue[r_rd_ptr].file_size;
    assign o_out_ch.packet_kind = r_queue[r_rd_ptr].packet_kind;
    assign o_out_ch.status      = r_queue[r_rd_ptr].status;
    assign o_out_ch.last_result = r_queue[r_rd_ptr].last_result;

    `FTPP_ASSERT_SAME(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= 3'(Depth), "queue overfilled")
    `FTPP_ASSERT_NEXT(a_idle_after_end, i_clk, i_rst_n, w_accept && i_in_ch.last_byte, r_phase == PH_IDLE, "parser not idle after packet end")
    `FTPP_ASSERT_NEXT(a_queue_grows, i_clk, i_rst_n, w_accept && !w_pop, r_count > $past(r_count), "accepted byte left no result")
    `FTPP_ASSERT_SAME(a_status_is_last, i_clk, i_rst_n, o_out_ch.valid && o_out_ch.out_kind == OK_STATUS, o_out_ch.last_result, "status result not marked last")

endmodule
